// ----- src/mcrt_pkg.sv -----
// mcrt_pkg: register indexes, fixed field widths and the control struct
// shared by the multi-plane cache read timing modules; no dependencies
`timescale 1ns / 1ps

package mcrt_pkg;

    // fixed field widths
    localparam int XFER_W        = 16;
    localparam int CNT_W         = 3;
    localparam int PAGES_W       = 9;
    localparam int LOAD_W        = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int OUT_TIME_W    = 32;
    localparam int OUT_PLANE_W   = 2;
    localparam int OUT_PAGE_W    = 8;
    localparam int NUM_PAGE_REGS = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_THREE   = 3'd5;

    // register reset values
    localparam logic [XFER_W-1:0]  RST_TRANSFER_TIME = 16'd1;
    localparam logic [CNT_W-1:0]   RST_PLANE_COUNT   = 3'd2;
    localparam logic [PAGES_W-1:0] RST_PAGES         = 9'd2;

    // per-cell control from the sequencer
    typedef struct packed {
        logic clr;        // position fell outside the grid: start from cell zero
        logic active;     // page lies below the plane's page count
        logic final_row;  // cell sits on the last row of the grid
        logic last;       // final cell of the grid
    } mcrt_ctrl_t;

endpackage

// ----- src/mcrt_cell_calc.sv -----
// mcrt_cell_calc: max-plus step for one cell, saturating adds
// depends on mcrt_pkg
`timescale 1ns / 1ps

module mcrt_cell_calc
    import mcrt_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic [LOAD_W-1:0]    load_time,
    input  logic [XFER_W-1:0]    transfer_time,
    input  logic                 active,
    input  logic [TIME_BITS-1:0] own_prev_two,
    input  logic [TIME_BITS-1:0] own_load_prev,
    input  logic [TIME_BITS-1:0] own_prev,
    input  logic [TIME_BITS-1:0] neighbour,
    output logic [TIME_BITS-1:0] load_end,
    output logic [TIME_BITS-1:0] transfer_end
);

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    endfunction

    logic [TIME_BITS-1:0] load_base;
    logic [TIME_BITS-1:0] load_val;
    logic [TIME_BITS-1:0] xfer_base;
    logic [TIME_BITS-1:0] xfer_max;

    always_comb begin
        load_base = (own_prev_two > own_load_prev) ? own_prev_two : own_load_prev;
        load_val  = sat_add(TIME_BITS'(load_time), load_base);
        xfer_base = (own_prev > neighbour) ? own_prev : neighbour;
        xfer_max  = (xfer_base > load_val) ? xfer_base : load_val;
        if (active) begin
            load_end     = load_val;
            transfer_end = sat_add(TIME_BITS'(transfer_time), xfer_max);
        end else begin
            load_end     = '0;
            transfer_end = '0;
        end
    end

endmodule

// ----- src/mcrt_sequencer.sv -----
// mcrt_sequencer: configuration registers, grid size and cell position
// depends on mcrt_pkg
`timescale 1ns / 1ps

module mcrt_sequencer
    import mcrt_pkg::*;
#(
    parameter int MAX_PLANES = 4,
    parameter int MAX_PAGES  = 256,
    localparam int PW = $clog2(MAX_PLANES),
    localparam int GW = $clog2(MAX_PAGES)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  advance,
    output logic [XFER_W-1:0]     transfer_time,
    output mcrt_ctrl_t            ctrl,
    output logic [PW-1:0]         plane_idx,
    output logic [GW-1:0]         page_idx,
    output logic [PW-1:0]         last_plane
);

    localparam int NW  = $clog2(MAX_PLANES + 1);
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int NCW = (NW > CNT_W) ? NW : CNT_W;
    localparam int PCW = (CW > PAGES_W) ? CW : PAGES_W;
    localparam int RW  = $clog2(NUM_PAGE_REGS);

    logic [XFER_W-1:0]  xfer_time_reg;
    logic [CNT_W-1:0]   plane_cnt_reg;
    logic [PAGES_W-1:0] pages_reg [NUM_PAGE_REGS];

    logic [PW-1:0] plane_pos_reg, plane_pos_next;
    logic [GW-1:0] page_pos_reg,  page_pos_next;

    logic [NCW-1:0] pc_ext;
    logic [NW-1:0]  n_planes;
    logic [CW-1:0]  plane_pages [MAX_PLANES];
    logic [CW-1:0]  rows;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xfer_time_reg <= RST_TRANSFER_TIME;
            plane_cnt_reg <= RST_PLANE_COUNT;
            for (int k = 0; k < NUM_PAGE_REGS; k++) begin
                pages_reg[k] <= RST_PAGES;
            end
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_TRANSFER_TIME: xfer_time_reg <= cfg_wr_data;
                CFG_PLANE_COUNT:   plane_cnt_reg <= cfg_wr_data[CNT_W-1:0];
                CFG_PAGES_ZERO:    pages_reg[0]  <= cfg_wr_data[PAGES_W-1:0];
                CFG_PAGES_ONE:     pages_reg[1]  <= cfg_wr_data[PAGES_W-1:0];
                CFG_PAGES_TWO:     pages_reg[2]  <= cfg_wr_data[PAGES_W-1:0];
                CFG_PAGES_THREE:   pages_reg[3]  <= cfg_wr_data[PAGES_W-1:0];
                default: ;
            endcase
        end
    end

    assign transfer_time = xfer_time_reg;

    // grid size from the configuration
    always_comb begin
        logic [PCW-1:0] raw;
        logic [RW-1:0]  sel;
        pc_ext = NCW'(plane_cnt_reg);
        if (pc_ext < NCW'(2)) begin
            n_planes = NW'(2);
        end else if (pc_ext > NCW'(MAX_PLANES)) begin
            n_planes = NW'(MAX_PLANES);
        end else begin
            n_planes = NW'(pc_ext);
        end
        rows = CW'(1);
        for (int k = 0; k < MAX_PLANES; k++) begin
            sel = (k < NUM_PAGE_REGS) ? RW'(k) : RW'(NUM_PAGE_REGS - 1);
            raw = PCW'(pages_reg[sel]);
            plane_pages[k] = (raw > PCW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(raw);
            if ((NW'(k) < n_planes) && (plane_pages[k] > rows)) begin
                rows = plane_pages[k];
            end
        end
    end

    // effective position and cell flags
    always_comb begin
        ctrl.clr       = (NW'(plane_pos_reg) >= n_planes) || (CW'(page_pos_reg) >= rows);
        plane_idx      = ctrl.clr ? '0 : plane_pos_reg;
        page_idx       = ctrl.clr ? '0 : page_pos_reg;
        last_plane     = PW'(n_planes - NW'(1));
        ctrl.active    = CW'(page_idx) < plane_pages[plane_idx];
        ctrl.final_row = CW'(page_idx) == (rows - CW'(1));
        ctrl.last      = ctrl.final_row && (plane_idx == last_plane);

        plane_pos_next = plane_pos_reg;
        page_pos_next  = page_pos_reg;
        if (advance) begin
            if (ctrl.last) begin
                plane_pos_next = '0;
                page_pos_next  = '0;
            end else if (plane_idx == last_plane) begin
                plane_pos_next = '0;
                page_pos_next  = page_idx + GW'(1);
            end else begin
                plane_pos_next = plane_idx + PW'(1);
                page_pos_next  = page_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_pos_reg <= '0;
            page_pos_reg  <= '0;
        end else begin
            plane_pos_reg <= plane_pos_next;
            page_pos_reg  <= page_pos_next;
        end
    end

endmodule

// ----- src/multiplane_cache_read_timing.sv -----
// multiplane_cache_read_timing: top level of the multi-plane cache read timing block
// output: each result is loaded into the output register on its input transfer
// throughput: one cell per cycle; s_ready is low only while a result waits unread
// reset: synchronous active-low aresetn clears position, per-plane times and the
// output valid; configuration registers return to their reset values
`timescale 1ns / 1ps

module multiplane_cache_read_timing
    import mcrt_pkg::*;
#(
    parameter int MAX_PLANES = 4,
    parameter int MAX_PAGES  = 256,
    parameter int TIME_BITS  = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // cell input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [LOAD_W-1:0]      s_load_time,
    // cell result
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [OUT_PLANE_W-1:0] m_cell_plane,
    output logic [OUT_PAGE_W-1:0]  m_cell_page,
    output logic [OUT_TIME_W-1:0]  m_load_end,
    output logic [OUT_TIME_W-1:0]  m_transfer_end,
    output logic                   m_last_cell,
    output logic [OUT_TIME_W-1:0]  m_total_time
);

    localparam int PW = $clog2(MAX_PLANES);
    localparam int GW = $clog2(MAX_PAGES);

    // sequencer outputs
    mcrt_ctrl_t        ctrl;
    logic [XFER_W-1:0] transfer_time;
    logic [PW-1:0]     plane_idx;
    logic [GW-1:0]     page_idx;
    logic [PW-1:0]     last_plane;
    logic [PW-1:0]     nb_idx;

    logic accept;

    // per-plane history of the recurrence
    logic [TIME_BITS-1:0] tep_reg  [MAX_PLANES];
    logic [TIME_BITS-1:0] tep_next [MAX_PLANES];
    logic [TIME_BITS-1:0] tep2_reg  [MAX_PLANES];
    logic [TIME_BITS-1:0] tep2_next [MAX_PLANES];
    logic [TIME_BITS-1:0] lep_reg  [MAX_PLANES];
    logic [TIME_BITS-1:0] lep_next [MAX_PLANES];
    logic [TIME_BITS-1:0] frm_reg, frm_next;

    // terms read for the current cell, zero when the grid restarts
    logic [TIME_BITS-1:0] own_prev;
    logic [TIME_BITS-1:0] own_prev_two;
    logic [TIME_BITS-1:0] own_load_prev;
    logic [TIME_BITS-1:0] neighbour;
    logic [TIME_BITS-1:0] frm_eff;
    logic [TIME_BITS-1:0] load_end;
    logic [TIME_BITS-1:0] transfer_end;
    logic [TIME_BITS-1:0] total;

    // output register
    logic                   m_valid_reg;
    logic [OUT_PLANE_W-1:0] cell_plane_reg;
    logic [OUT_PAGE_W-1:0]  cell_page_reg;
    logic [OUT_TIME_W-1:0]  load_end_reg;
    logic [OUT_TIME_W-1:0]  transfer_end_reg;
    logic                   last_cell_reg;
    logic [OUT_TIME_W-1:0]  total_time_reg;

    // input is taken whenever the output register is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mcrt_sequencer #(
        .MAX_PLANES (MAX_PLANES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_sequencer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .advance       (accept),
        .transfer_time (transfer_time),
        .ctrl          (ctrl),
        .plane_idx     (plane_idx),
        .page_idx      (page_idx),
        .last_plane    (last_plane)
    );

    // plane zero waits on the last plane, others on the plane before
    assign nb_idx = (plane_idx == '0) ? last_plane : plane_idx - PW'(1);

    always_comb begin
        if (ctrl.clr) begin
            own_prev      = '0;
            own_prev_two  = '0;
            own_load_prev = '0;
            neighbour     = '0;
            frm_eff       = '0;
        end else begin
            own_prev      = tep_reg[plane_idx];
            own_prev_two  = tep2_reg[plane_idx];
            own_load_prev = lep_reg[plane_idx];
            neighbour     = tep_reg[nb_idx];
            frm_eff       = frm_reg;
        end
    end

    mcrt_cell_calc #(
        .TIME_BITS (TIME_BITS)
    ) u_cell_calc (
        .load_time     (s_load_time),
        .transfer_time (transfer_time),
        .active        (ctrl.active),
        .own_prev_two  (own_prev_two),
        .own_load_prev (own_load_prev),
        .own_prev      (own_prev),
        .neighbour     (neighbour),
        .load_end      (load_end),
        .transfer_end  (transfer_end)
    );

    // final-row maximum including this cell
    assign total = (transfer_end > frm_eff) ? transfer_end : frm_eff;

    // history update: written plane shifts, the rest holds or clears; the final cell clears all
    always_comb begin
        for (int k = 0; k < MAX_PLANES; k++) begin
            tep_next[k]  = tep_reg[k];
            tep2_next[k] = tep2_reg[k];
            lep_next[k]  = lep_reg[k];
            if (accept) begin
                if (ctrl.last) begin
                    tep_next[k]  = '0;
                    tep2_next[k] = '0;
                    lep_next[k]  = '0;
                end else if (PW'(k) == plane_idx) begin
                    tep2_next[k] = own_prev;
                    tep_next[k]  = transfer_end;
                    lep_next[k]  = load_end;
                end else if (ctrl.clr) begin
                    tep_next[k]  = '0;
                    tep2_next[k] = '0;
                    lep_next[k]  = '0;
                end
            end
        end
        frm_next = frm_reg;
        if (accept) begin
            if (ctrl.last) begin
                frm_next = '0;
            end else if (ctrl.final_row) begin
                frm_next = total;
            end else begin
                frm_next = frm_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_PLANES; k++) begin
                tep_reg[k]  <= '0;
                tep2_reg[k] <= '0;
                lep_reg[k]  <= '0;
            end
            frm_reg <= '0;
        end else begin
            for (int k = 0; k < MAX_PLANES; k++) begin
                tep_reg[k]  <= tep_next[k];
                tep2_reg[k] <= tep2_next[k];
                lep_reg[k]  <= lep_next[k];
            end
            frm_reg <= frm_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload, loaded on each input transfer
    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_plane_reg   <= OUT_PLANE_W'(plane_idx);
            cell_page_reg    <= OUT_PAGE_W'(page_idx);
            load_end_reg     <= OUT_TIME_W'(load_end);
            transfer_end_reg <= OUT_TIME_W'(transfer_end);
            last_cell_reg    <= ctrl.last;
            total_time_reg   <= ctrl.last ? OUT_TIME_W'(total) : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cell_plane   = cell_plane_reg;
    assign m_cell_page    = cell_page_reg;
    assign m_load_end     = load_end_reg;
    assign m_transfer_end = transfer_end_reg;
    assign m_last_cell    = last_cell_reg;
    assign m_total_time   = total_time_reg;

endmodule

// ----- src/mcrt_checker.sv -----
// mcrt_checker: port-level assertions for multiplane_cache_read_timing, and its bind
// depends on mcrt_pkg
`timescale 1ns / 1ps

module mcrt_checker
    import mcrt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [OUT_PLANE_W-1:0] m_cell_plane,
    input logic [OUT_PAGE_W-1:0]  m_cell_page,
    input logic [OUT_TIME_W-1:0]  m_load_end,
    input logic [OUT_TIME_W-1:0]  m_transfer_end,
    input logic                   m_last_cell,
    input logic [OUT_TIME_W-1:0]  m_total_time
);

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_plane) && $stable(m_cell_page)
            && $stable(m_load_end) && $stable(m_transfer_end) && $stable(m_last_cell)
            && $stable(m_total_time))
        else $error("stalled result changed");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side only stalls behind an unread result
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input stalled without a waiting result");

    // total time only on the final cell
    a_total_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_cell |-> m_total_time == '0)
        else $error("total time away from the final cell");

endmodule

bind multiplane_cache_read_timing mcrt_checker u_mcrt_checker (.*);
